// ===== src/arv_pkg.sv =====
package arv_pkg;

  localparam int DATA_W        = 32;  // Q16.16 coordinates
  localparam int ANGLE_W       = 16;  // binary angle, full turn = 2^16
  localparam int CMD_W         = 2;
  localparam int ANG_W         = 32;  // phase accumulator, full turn = 2^32
  localparam int CORDIC_W      = 34;  // Q2.30 plus guard bits
  localparam int CORDIC_STAGES = 16;  // 8 .. 32
  localparam int ATAN_ENTRIES  = 32;

  localparam logic signed [CORDIC_W-1:0] INV_GAIN = CORDIC_W'(652032874);

  typedef enum logic [CMD_W-1:0] {
    CMD_ROT_X = 2'd0,
    CMD_ROT_Y = 2'd1,
    CMD_ROT_Z = 2'd2,
    CMD_PASS  = 2'd3
  } cmd_e;

  // Item data carried alongside the sine/cosine generator
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    cmd_e                     cmd;
    logic [1:0]               quad;
  } side_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] cx;
    logic signed [CORDIC_W-1:0] cy;
    logic signed [ANG_W-1:0]    ang;
    side_t                      side;
  } cordic_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
    logic signed [ANG_W-1:0] val;
    case (idx)
      0:       val = 32'sd536870912;
      1:       val = 32'sd316933406;
      2:       val = 32'sd167458907;
      3:       val = 32'sd85004756;
      4:       val = 32'sd42667331;
      5:       val = 32'sd21354465;
      6:       val = 32'sd10679838;
      7:       val = 32'sd5340245;
      8:       val = 32'sd2670163;
      9:       val = 32'sd1335087;
      10:      val = 32'sd667544;
      11:      val = 32'sd333772;
      12:      val = 32'sd166886;
      13:      val = 32'sd83443;
      14:      val = 32'sd41722;
      15:      val = 32'sd20861;
      16:      val = 32'sd10430;
      17:      val = 32'sd5215;
      18:      val = 32'sd2608;
      19:      val = 32'sd1304;
      20:      val = 32'sd652;
      21:      val = 32'sd326;
      22:      val = 32'sd163;
      23:      val = 32'sd81;
      24:      val = 32'sd41;
      25:      val = 32'sd20;
      26:      val = 32'sd10;
      27:      val = 32'sd5;
      28:      val = 32'sd3;
      29:      val = 32'sd1;
      30:      val = 32'sd1;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/arv_if.sv =====
interface arv_in_if;
  import arv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_in;
  logic signed [DATA_W-1:0] y_in;
  logic signed [DATA_W-1:0] z_in;
  logic [ANGLE_W-1:0]       angle;
  logic [CMD_W-1:0]         command;

  modport source (output valid, x_in, y_in, z_in, angle, command, input ready);
  modport sink   (input valid, x_in, y_in, z_in, angle, command, output ready);
endinterface

interface arv_out_if;
  import arv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_out;
  logic signed [DATA_W-1:0] y_out;
  logic signed [DATA_W-1:0] z_out;

  modport source (output valid, x_out, y_out, z_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, output ready);
endinterface

// ===== src/arv_cordic.sv =====
module arv_cordic (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  arv_pkg::cordic_t  data_i,
  output logic              valid_o,
  output arv_pkg::cordic_t  data_o
);
  import arv_pkg::*;

  // One micro-rotation per register stage
  logic    [CORDIC_STAGES-1:0] v_q;
  cordic_t                     st_q [CORDIC_STAGES];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    localparam logic signed [ANG_W-1:0] AtanK = atan_entry(k);

    logic                       src_v;
    cordic_t                    src;
    cordic_t                    st_d;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;

    if (k == 0) begin : g_head
      assign src_v = valid_i;
      assign src   = data_i;
    end else begin : g_body
      assign src_v = v_q[k-1];
      assign src   = st_q[k-1];
    end

    always_comb begin
      dx   = src.cy >>> k;
      dy   = src.cx >>> k;
      st_d = src;
      if (!src.ang[ANG_W-1]) begin
        st_d.cx  = src.cx - dx;
        st_d.cy  = src.cy + dy;
        st_d.ang = src.ang - AtanK;
      end else begin
        st_d.cx  = src.cx + dx;
        st_d.cy  = src.cy - dy;
        st_d.ang = src.ang + AtanK;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES-1];
  assign data_o  = st_q[CORDIC_STAGES-1];

endmodule

// ===== src/axis_rotate_3d_vector.sv =====
// Path from input transfer to output valid: stage 0, CORDIC stages, operand, product, sum and output registers.
// Throughput: one vector per cycle while the skid register is empty; one CORDIC micro-rotation per register stage.
// Input ready drops only while a result sits in the skid register behind a held output.
// Reset: asynchronous, active low; clears all valid bits and the output/skid flags.
// Datapath registers carry no reset.
module axis_rotate_3d_vector (
  input  logic clk_i,
  input  logic rst_ni,
  arv_in_if.sink    in_ch_i,
  arv_out_if.source out_ch_o
);
  import arv_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam int FRAC_SHIFT = 30;                        // Q18.46 -> Q16.16
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] SAT_MAX  = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] SAT_MIN  = -PROD_W'(64'sd2147483648);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec_t;

  // Round half up, then saturate to Q16.16
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] acc);
    logic signed [PROD_W-1:0] t;
    logic signed [PROD_W-1:0] r;
    t = acc + RND_HALF;
    r = t >>> FRAC_SHIFT;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r[DATA_W-1:0];
  endfunction

  // Pipeline advances as one; only a full skid register stops it
  logic en;

  // ---------------------------------------------------------------
  // Stage 0: capture, quadrant reduction of the angle
  // ---------------------------------------------------------------
  logic [ANGLE_W-1:0] ang_rnd;
  logic [1:0]         quad;
  logic [ANGLE_W-1:0] ang_res;
  cordic_t            s0_d;
  logic               s0_v_q;
  cordic_t            s0_q;

  always_comb begin
    ang_rnd        = in_ch_i.angle + ANGLE_W'(16'h2000);
    quad           = ang_rnd[ANGLE_W-1 -: 2];
    ang_res        = in_ch_i.angle - {quad, {(ANGLE_W-2){1'b0}}};
    s0_d.cx        = INV_GAIN;
    s0_d.cy        = '0;
    s0_d.ang       = $signed({ang_res, {(ANG_W-ANGLE_W){1'b0}}});
    s0_d.side.x    = in_ch_i.x_in;
    s0_d.side.y    = in_ch_i.y_in;
    s0_d.side.z    = in_ch_i.z_in;
    s0_d.side.cmd  = cmd_e'(in_ch_i.command);
    s0_d.side.quad = quad;
  end

  // ---------------------------------------------------------------
  // CORDIC stages
  // ---------------------------------------------------------------
  logic    cd_v;
  cordic_t cd_q;

  arv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .data_i  (s0_q),
    .valid_o (cd_v),
    .data_o  (cd_q)
  );

  // ---------------------------------------------------------------
  // Quadrant fix and operand select
  // For every axis: first = a*c - b*s, second = a*s + b*c
  // ---------------------------------------------------------------
  logic signed [CORDIC_W-1:0] c_full;
  logic signed [CORDIC_W-1:0] s_full;
  logic signed [DATA_W-1:0]   op_a;
  logic signed [DATA_W-1:0]   op_b;

  logic                     fx_v_q;
  logic signed [DATA_W-1:0] fx_a_q, fx_b_q, fx_c_q, fx_s_q;
  side_t                    fx_side_q;

  always_comb begin
    unique case (cd_q.side.quad)
      2'd0: begin
        c_full = cd_q.cx;
        s_full = cd_q.cy;
      end
      2'd1: begin
        c_full = -cd_q.cy;
        s_full = cd_q.cx;
      end
      2'd2: begin
        c_full = -cd_q.cx;
        s_full = -cd_q.cy;
      end
      default: begin
        c_full = cd_q.cy;
        s_full = -cd_q.cx;
      end
    endcase

    unique case (cd_q.side.cmd)
      CMD_ROT_X: begin
        op_a = cd_q.side.y;
        op_b = cd_q.side.z;
      end
      CMD_ROT_Y: begin
        op_a = cd_q.side.z;
        op_b = cd_q.side.x;
      end
      CMD_ROT_Z, CMD_PASS: begin
        op_a = cd_q.side.x;
        op_b = cd_q.side.y;
      end
      default: begin
        op_a = cd_q.side.x;
        op_b = cd_q.side.y;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Products and sums
  // ---------------------------------------------------------------
  logic                     ml_v_q;
  logic signed [PROD_W-1:0] ml_ac_q, ml_bs_q, ml_as_q, ml_bc_q;
  side_t                    ml_side_q;

  logic                     sm_v_q;
  logic signed [PROD_W-1:0] sm_ra_q, sm_rb_q;
  side_t                    sm_side_q;

  // ---------------------------------------------------------------
  // Round, map back onto axes
  // ---------------------------------------------------------------
  logic signed [DATA_W-1:0] rnd_a;
  logic signed [DATA_W-1:0] rnd_b;
  vec_t                     res;

  always_comb begin
    rnd_a = round_sat(sm_ra_q);
    rnd_b = round_sat(sm_rb_q);
    res.x = sm_side_q.x;
    res.y = sm_side_q.y;
    res.z = sm_side_q.z;
    unique case (sm_side_q.cmd)
      CMD_ROT_X: begin
        res.y = rnd_a;
        res.z = rnd_b;
      end
      CMD_ROT_Y: begin
        res.z = rnd_a;
        res.x = rnd_b;
      end
      CMD_ROT_Z: begin
        res.x = rnd_a;
        res.y = rnd_b;
      end
      default: begin
        // pass through, vector unchanged
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Output register plus skid register
  // ---------------------------------------------------------------
  logic ob_v_q, ob_v_d;
  logic sk_v_q, sk_v_d;
  vec_t ob_q, ob_d;
  vec_t sk_q, sk_d;
  logic ob_free;

  assign en      = ~sk_v_q;
  assign ob_free = ~ob_v_q | out_ch_o.ready;

  always_comb begin
    ob_v_d = ob_v_q;
    sk_v_d = sk_v_q;
    ob_d   = ob_q;
    sk_d   = sk_q;
    if (ob_free) begin
      if (sk_v_q) begin
        ob_d   = sk_q;
        ob_v_d = 1'b1;
        sk_v_d = 1'b0;
      end else begin
        ob_d   = res;
        ob_v_d = sm_v_q;
      end
    end else if (sm_v_q && en) begin
      sk_d   = res;
      sk_v_d = 1'b1;
    end
  end

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      fx_v_q <= 1'b0;
      ml_v_q <= 1'b0;
      sm_v_q <= 1'b0;
      ob_v_q <= 1'b0;
      sk_v_q <= 1'b0;
    end else begin
      if (en) begin
        s0_v_q <= in_ch_i.valid;
        fx_v_q <= cd_v;
        ml_v_q <= fx_v_q;
        sm_v_q <= ml_v_q;
      end
      ob_v_q <= ob_v_d;
      sk_v_q <= sk_v_d;
    end
  end

  // ---------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q      <= s0_d;
      fx_a_q    <= op_a;
      fx_b_q    <= op_b;
      fx_c_q    <= c_full[DATA_W-1:0];
      fx_s_q    <= s_full[DATA_W-1:0];
      fx_side_q <= cd_q.side;
      ml_ac_q   <= PROD_W'(fx_a_q) * PROD_W'(fx_c_q);
      ml_bs_q   <= PROD_W'(fx_b_q) * PROD_W'(fx_s_q);
      ml_as_q   <= PROD_W'(fx_a_q) * PROD_W'(fx_s_q);
      ml_bc_q   <= PROD_W'(fx_b_q) * PROD_W'(fx_c_q);
      ml_side_q <= fx_side_q;
      sm_ra_q   <= ml_ac_q - ml_bs_q;
      sm_rb_q   <= ml_as_q + ml_bc_q;
      sm_side_q <= ml_side_q;
    end
    ob_q <= ob_d;
    sk_q <= sk_d;
  end

  assign in_ch_i.ready  = en;
  assign out_ch_o.valid = ob_v_q;
  assign out_ch_o.x_out = ob_q.x;
  assign out_ch_o.y_out = ob_q.y;
  assign out_ch_o.z_out = ob_q.z;

endmodule

// ===== src/arv_checker.sv =====
module arv_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [arv_pkg::DATA_W-1:0] x_out_i,
  input logic signed [arv_pkg::DATA_W-1:0] y_out_i,
  input logic signed [arv_pkg::DATA_W-1:0] z_out_i
);
  import arv_pkg::*;

  // pipeline stages plus output and skid registers
  localparam int PIPE_CAP = CORDIC_STAGES + 6;
  localparam int CNT_W    = $clog2(PIPE_CAP + 1) + 1;

  logic             in_xfer;
  logic             out_xfer;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;
  assign cnt_d    = cnt_q + CNT_W'(in_xfer) - CNT_W'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // no result without an earlier input transfer
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cnt_q != '0))
    else $error("result offered with no item in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_CAP))
    else $error("more items in flight than storage holds");

  // input only backs up behind a held result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(x_out_i) && $stable(y_out_i) && $stable(z_out_i)))
    else $error("held result changed or dropped");

endmodule

bind axis_rotate_3d_vector arv_checker u_arv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .x_out_i     (out_ch_o.x_out),
  .y_out_i     (out_ch_o.y_out),
  .z_out_i     (out_ch_o.z_out)
);
